>>> hw/rtl/plit_pkg.sv
// Shared types and constants for the piecewise linear interpolation table.
package plit_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 256;
  localparam int unsigned DEF_VALUE_WIDTH = 32;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_DUP   = 3'd2,
    ST_FULL  = 3'd3,
    ST_SAT   = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SRCH,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_INS_RD,
    S_INS_CHK,
    S_SHIFT,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_WR,
    S_QA_RD,
    S_QA,
    S_QB_RD,
    S_QB,
    S_MUL,
    S_DIV,
    S_DIV_WAIT,
    S_SUM,
    S_DONE
  } fsm_t;

endpackage

>>> hw/rtl/plit_div.sv
// Serial restoring divider: 2W-bit dividend by W-bit divisor, one bit a cycle.
module plit_div #(
  parameter int unsigned VALUE_WIDTH = plit_pkg::DEF_VALUE_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [2*VALUE_WIDTH-1:0]   dividend,
  input  logic [VALUE_WIDTH-1:0]     divisor,
  output logic                       done,
  output logic [2*VALUE_WIDTH-1:0]   quotient
);
  import plit_pkg::*;

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned CW = $clog2(2 * W + 1);

  logic [W-1:0]     rem_r;
  logic [2*W-1:0]   quo_r;
  logic [W-1:0]     dsr_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [W:0]       sh;
  logic [W:0]       sub;
  logic             ge;

  assign sh  = {rem_r, quo_r[2*W-1]};
  assign sub = sh - {1'b0, dsr_r};
  assign ge  = (sh >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(2 * W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? sub[W-1:0] : sh[W-1:0];
      quo_r <= {quo_r[2*W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> hw/rtl/piecewise_linear_interpolation_table_core.sv
// Top level of the piecewise linear interpolation table.
//
//  channel | dir | ports          | content
//  --------+-----+----------------+-------------------------------------------
//  in      | in  | in_tvalid/rdy  | tuser: action; tdata: x_value, y_value
//  out     | out | out_tvalid/rdy | tuser: status; tdata: y_result, entry_count
//
// One item at a time. Points live in one memory word {y, x}, one read port
// with a registered output and one write port.
// Query: a binary search (up to 9 steps on a full table), two entry reads, one
// multiply, then the serial divide. One-point tables skip the search; exact hits
// and one-point tables also skip the second read, the multiply and the divide.
// Insert: the same search, then each entry above the slot is moved up one place.
// Clear and unused actions skip to S_DONE. Reset zeroes the point count only.
// Input is taken while a finished result still waits in the output register;
// a stalled output holds the next result in the sequencer until it drains.
module piecewise_linear_interpolation_table_core #(
  parameter int unsigned TABLE_DEPTH = plit_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned VALUE_WIDTH = plit_pkg::DEF_VALUE_WIDTH,
  localparam int unsigned IN_DW  = ((2 * VALUE_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_DW = ((VALUE_WIDTH + 9 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // x_value, y_value, zero pad
  input  logic [1:0]        in_tuser,   // action
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // y_result, entry_count, zero pad
  output logic [2:0]        out_tuser   // status
);
  import plit_pkg::*;

  localparam int unsigned W    = VALUE_WIDTH;
  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CNTW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SW   = 2 * W + 2;

  // point store
  logic [2*W-1:0] mem [TABLE_DEPTH];
  logic [2*W-1:0] mem_q_r;
  logic           rd_en, wr_en;
  logic [AW-1:0]  rd_addr, wr_addr;
  logic [2*W-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (rd_en) mem_q_r <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  logic [W-1:0] mem_x, mem_y;
  assign mem_x = mem_q_r[W-1:0];
  assign mem_y = mem_q_r[2*W-1:W];

  fsm_t             state_r, state_nxt;
  logic [CNTW-1:0]  cnt_r, lo_r, hi_r, idx_r;
  action_t          act_r;
  logic [W-1:0]     x_r, y_r, xa_r, ya_r;
  logic [AW-1:0]    a_r, b_r;
  logic [W-1:0]     m1_r, m2_r, m3_r;
  logic             neg_r, zero_r;
  logic [2*W-1:0]   prod_r;
  logic [W-1:0]     res_r;
  status_t          stat_r;
  logic             out_valid_r;
  logic [W-1:0]     out_y_r;
  logic [8:0]       out_cnt_r;
  status_t          out_stat_r;

  logic [CNTW:0]    lohi;
  logic [CNTW-1:0]  mid;
  logic [CNTW-1:0]  cnt_m1;
  logic             cmp_go;
  logic             out_free;
  logic             div_start, div_done;
  logic [2*W-1:0]   quo;

  assign lohi     = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid      = lohi[CNTW:1];
  assign cnt_m1   = cnt_r - CNTW'(1);
  // insert looks for the first x >= key, query for the first x > key
  assign cmp_go   = (act_r == ACT_INSERT) ? ($signed(mem_x) <  $signed(x_r))
                                          : ($signed(mem_x) <= $signed(x_r));
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  function automatic logic [W:0] sdiff(input logic [W-1:0] p, input logic [W-1:0] q);
    sdiff = $signed({p[W-1], p}) - $signed({q[W-1], q});
  endfunction

  function automatic logic [W-1:0] mag(input logic [W:0] d);
    logic [W:0] n;
    n   = -d;
    mag = d[W] ? n[W-1:0] : d[W-1:0];
  endfunction

  function automatic logic [AW-1:0] cnt_m1_idx(input logic [CNTW-1:0] v);
    logic [CNTW-1:0] t;
    t = v - CNTW'(1);
    cnt_m1_idx = t[AW-1:0];
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          priority case (action_t'(in_tuser))
            ACT_INSERT: state_nxt = S_SRCH;
            ACT_QUERY: begin
              if (cnt_r == '0) state_nxt = S_DONE;
              else if (cnt_r == CNTW'(1)) state_nxt = S_QA_RD;
              else state_nxt = S_SRCH;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) state_nxt = S_SRCH_RD;
        else if (act_r == ACT_QUERY) state_nxt = S_QA_RD;
        else if (lo_r < cnt_r) state_nxt = S_INS_RD;
        else if (cnt_r >= CNTW'(TABLE_DEPTH)) state_nxt = S_DONE;
        else state_nxt = S_SHIFT;
      end
      S_SRCH_RD:  state_nxt = S_SRCH_CMP;
      S_SRCH_CMP: state_nxt = S_SRCH;
      S_INS_RD:   state_nxt = S_INS_CHK;
      S_INS_CHK: begin
        if (mem_x == x_r || cnt_r >= CNTW'(TABLE_DEPTH)) state_nxt = S_DONE;
        else state_nxt = S_SHIFT;
      end
      S_SHIFT:    state_nxt = (idx_r > lo_r) ? S_SHIFT_RD : S_INS_WR;
      S_SHIFT_RD: state_nxt = S_SHIFT_WR;
      S_SHIFT_WR: state_nxt = S_SHIFT;
      S_INS_WR:   state_nxt = S_DONE;
      S_QA_RD:    state_nxt = S_QA;
      S_QA: begin
        if (cnt_r == CNTW'(1) || mem_x == x_r) state_nxt = S_DONE;
        else state_nxt = S_QB_RD;
      end
      S_QB_RD:    state_nxt = S_QB;
      S_QB:       state_nxt = S_MUL;
      S_MUL:      state_nxt = S_DIV;
      S_DIV:      state_nxt = zero_r ? S_SUM : S_DIV_WAIT;
      S_DIV_WAIT: state_nxt = div_done ? S_SUM : S_DIV_WAIT;
      S_SUM:      state_nxt = S_DONE;
      S_DONE:     state_nxt = out_free ? S_IDLE : S_DONE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // memory and divider controls
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = mem_q_r;
    div_start = 1'b0;
    unique case (state_r)
      S_SRCH_RD: begin
        rd_en   = 1'b1;
        rd_addr = mid[AW-1:0];
      end
      S_INS_RD: begin
        rd_en   = 1'b1;
        rd_addr = lo_r[AW-1:0];
      end
      S_SHIFT_RD: begin
        rd_en   = 1'b1;
        rd_addr = cnt_m1_idx(idx_r);
      end
      S_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_r[AW-1:0];
      end
      S_INS_WR: begin
        wr_en   = 1'b1;
        wr_addr = lo_r[AW-1:0];
        wr_data = {y_r, x_r};
      end
      S_QA_RD: begin
        rd_en   = 1'b1;
        rd_addr = a_r;
      end
      S_QB_RD: begin
        rd_en   = 1'b1;
        rd_addr = b_r;
      end
      S_DIV:   div_start = !zero_r;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (state_r == S_IDLE && in_tvalid && action_t'(in_tuser) == ACT_CLEAR)
        cnt_r <= '0;
      if (state_r == S_INS_WR) cnt_r <= cnt_r + CNTW'(1);
    end
  end

  // datapath
  logic [W:0]    d1, d2, d3;
  logic [SW-1:0] base_s, q_s, sum_s;
  localparam logic [SW-1:0] MAXV = {{(W + 3){1'b0}}, {(W - 1){1'b1}}};
  localparam logic [SW-1:0] MINV = ~MAXV;

  assign d1     = sdiff(x_r, xa_r);
  assign d2     = sdiff(mem_y, ya_r);
  assign d3     = sdiff(mem_x, xa_r);
  assign base_s = {{(W + 2){ya_r[W-1]}}, ya_r};
  assign q_s    = {2'b00, (zero_r ? {(2 * W){1'b0}} : quo)};
  assign sum_s  = neg_r ? (base_s - q_s) : (base_s + q_s);

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        act_r  <= action_t'(in_tuser);
        x_r    <= in_tdata[W-1:0];
        y_r    <= in_tdata[2*W-1:W];
        lo_r   <= '0;
        hi_r   <= cnt_r;
        idx_r  <= cnt_r;
        a_r    <= '0;
        res_r  <= '0;
        stat_r <= (action_t'(in_tuser) == ACT_QUERY && cnt_r == '0) ? ST_EMPTY : ST_OK;
      end
      S_SRCH: begin
        if (!(lo_r < hi_r) && act_r == ACT_QUERY) begin
          if (lo_r == '0) begin
            a_r <= '0;
            b_r <= AW'(1);
          end else if (lo_r == cnt_r) begin
            a_r <= cnt_m1[AW-1:0];
            b_r <= cnt_m1_idx(cnt_m1);
          end else begin
            a_r <= cnt_m1_idx(lo_r);
            b_r <= lo_r[AW-1:0];
          end
        end else if (!(lo_r < hi_r) && !(lo_r < cnt_r) && cnt_r >= CNTW'(TABLE_DEPTH)) begin
          stat_r <= ST_FULL;
        end
      end
      S_SRCH_CMP: begin
        if (cmp_go) lo_r <= mid + CNTW'(1);
        else hi_r <= mid;
      end
      S_INS_CHK: begin
        if (mem_x == x_r) stat_r <= ST_DUP;
        else if (cnt_r >= CNTW'(TABLE_DEPTH)) stat_r <= ST_FULL;
      end
      S_SHIFT_WR: idx_r <= idx_r - CNTW'(1);
      S_QA: begin
        xa_r  <= mem_x;
        ya_r  <= mem_y;
        res_r <= mem_y;
      end
      S_QB: begin
        m1_r  <= mag(d1);
        m2_r  <= mag(d2);
        m3_r  <= mag(d3);
        neg_r <= d1[W] ^ d2[W] ^ d3[W];
      end
      S_MUL: begin
        prod_r <= (2 * W)'(m1_r) * (2 * W)'(m2_r);
        zero_r <= (m1_r == '0) || (m2_r == '0) || (m3_r == '0);
      end
      S_SUM: begin
        if ($signed(sum_s) > $signed(MAXV)) begin
          res_r  <= MAXV[W-1:0];
          stat_r <= ST_SAT;
        end else if ($signed(sum_s) < $signed(MINV)) begin
          res_r  <= MINV[W-1:0];
          stat_r <= ST_SAT;
        end else begin
          res_r <= sum_s[W-1:0];
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_y_r    <= res_r;
          out_stat_r <= stat_r;
          out_cnt_r  <= 9'(cnt_r);
        end
      end
      default: ;
    endcase
  end

  plit_div #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (m3_r),
    .done     (div_done),
    .quotient (quo)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'({out_cnt_r, out_y_r});
  assign out_tuser  = out_stat_r;

endmodule

>>> hw/rtl/plit_chk.sv
// Port-level checker for the interpolation table, bound to the top level.
module plit_chk #(
  parameter int unsigned TABLE_DEPTH = plit_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned VALUE_WIDTH = plit_pkg::DEF_VALUE_WIDTH,
  localparam int unsigned IN_DW  = ((2 * VALUE_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_DW = ((VALUE_WIDTH + 9 + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [IN_DW-1:0]  in_tdata,
  input logic [1:0]        in_tuser,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata,
  input logic [2:0]        out_tuser
);
  import plit_pkg::*;

  localparam int unsigned W = VALUE_WIDTH;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= ST_SAT)
    else $error("bad status code");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[W+8:W] <= 9'(TABLE_DEPTH))
    else $error("entry count beyond depth");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_EMPTY |->
      out_tdata[W-1:0] == '0 && out_tdata[W+8:W] == '0)
    else $error("empty status with data");

endmodule

bind piecewise_linear_interpolation_table_core plit_chk #(
  .TABLE_DEPTH(TABLE_DEPTH),
  .VALUE_WIDTH(VALUE_WIDTH)
) u_plit_chk (.*);
